// ----- design/hmd_pkg.sv -----
// Package for the half-perimeter wirelength move-delta core.
// Holds field widths, default sizes, queue status type and width helpers.
// Used by every module of the block; depends on nothing else.
package hmd_pkg;

	// Default sizes of the configurable fields.
	localparam int COORD_WIDTH_DEF  = 32;
	localparam int WEIGHT_WIDTH_DEF = 16;

	// Fixed field widths.
	localparam int OFFSET_W = 24;
	localparam int NET_W    = 53;
	localparam int TOT_W    = 63;

	// Records of finished nets buffered between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Status that the record queue reports to its neighbors.
	typedef struct packed {
		logic not_empty;
		logic room2;
	} hmd_qstat_t;

	// Width of a pin position: the wider of node and offset plus one carry bit.
	function automatic int pos_width(input int cw);
		pos_width = ((cw > OFFSET_W) ? cw : OFFSET_W) + 1;
	endfunction

	// Input tdata width: all tdata fields rounded up to whole bytes.
	function automatic int in_data_width(input int cw, input int ww);
		in_data_width = ((4 * cw + 2 * OFFSET_W + ww + 7) / 8) * 8;
	endfunction

endpackage

// ----- design/hmd_front.sv -----
// Front part of the move-delta core: forms pin positions and widens the boxes.
// At a net end it pushes the final old and new boxes plus weight as one record.
// Depends on hmd_pkg.
module hmd_front import hmd_pkg::*; #(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int WEIGHT_WIDTH = WEIGHT_WIDTH_DEF,
	parameter int POS_W        = pos_width(COORD_WIDTH),
	parameter int REC_W        = 8 * POS_W + WEIGHT_WIDTH + 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [COORD_WIDTH-1:0]  node_x,
	input  logic signed [COORD_WIDTH-1:0]  node_y,
	input  logic signed [OFFSET_W-1:0]     pin_dx,
	input  logic signed [OFFSET_W-1:0]     pin_dy,
	input  logic                           is_moved,
	input  logic signed [COORD_WIDTH-1:0]  moved_x,
	input  logic signed [COORD_WIDTH-1:0]  moved_y,
	input  logic [WEIGHT_WIDTH-1:0]        net_weight,
	input  logic                           last_pin_of_net,
	input  logic                           last_of_query,
	input  hmd_qstat_t                     qstat,
	output logic                           push,
	output logic [REC_W-1:0]               push_data
);

	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W - 1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W - 1){1'b0}}};

	logic                            accept;
	logic signed [COORD_WIDTH-1:0]   cx, cy;
	logic signed [POS_W-1:0]         px, py, qx, qy;

	logic                            vld_s1;
	logic                            end_s1, qend_s1;
	logic [WEIGHT_WIDTH-1:0]         w_s1;
	logic signed [POS_W-1:0]         px_s1, py_s1, qx_s1, qy_s1;

	logic signed [POS_W-1:0]         omin_x_q, omax_x_q, omin_y_q, omax_y_q;
	logic signed [POS_W-1:0]         nmin_x_q, nmax_x_q, nmin_y_q, nmax_y_q;
	logic signed [POS_W-1:0]         omin_x, omax_x, omin_y, omax_y;
	logic signed [POS_W-1:0]         nmin_x, nmax_x, nmin_y, nmax_y;

	// A new pin is taken only while the queue can absorb this one and the one ahead.
	assign in_ready = qstat.room2;
	assign accept   = in_valid & in_ready;

	// Old and new pin positions; the new one uses the trial centre when moved.
	assign cx = is_moved ? moved_x : node_x;
	assign cy = is_moved ? moved_y : node_y;
	assign px = POS_W'(node_x) + POS_W'(pin_dx);
	assign py = POS_W'(node_y) + POS_W'(pin_dy);
	assign qx = POS_W'(cx) + POS_W'(pin_dx);
	assign qy = POS_W'(cy) + POS_W'(pin_dy);

	// Pin stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= px;
			py_s1   <= py;
			qx_s1   <= qx;
			qy_s1   <= qy;
			w_s1    <= net_weight;
			end_s1  <= last_pin_of_net | last_of_query;
			qend_s1 <= last_of_query;
		end
	end

	// Boxes widened by the staged pin.
	always_comb begin
		omin_x = (px_s1 < omin_x_q) ? px_s1 : omin_x_q;
		omax_x = (px_s1 > omax_x_q) ? px_s1 : omax_x_q;
		omin_y = (py_s1 < omin_y_q) ? py_s1 : omin_y_q;
		omax_y = (py_s1 > omax_y_q) ? py_s1 : omax_y_q;
		nmin_x = (qx_s1 < nmin_x_q) ? qx_s1 : nmin_x_q;
		nmax_x = (qx_s1 > nmax_x_q) ? qx_s1 : nmax_x_q;
		nmin_y = (qy_s1 < nmin_y_q) ? qy_s1 : nmin_y_q;
		nmax_y = (qy_s1 > nmax_y_q) ? qy_s1 : nmax_y_q;
	end

	// Box registers: cleared at reset and after each net end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omin_x_q <= POS_MAX;
			omax_x_q <= POS_MIN;
			omin_y_q <= POS_MAX;
			omax_y_q <= POS_MIN;
			nmin_x_q <= POS_MAX;
			nmax_x_q <= POS_MIN;
			nmin_y_q <= POS_MAX;
			nmax_y_q <= POS_MIN;
		end else if (vld_s1) begin
			if (end_s1) begin
				omin_x_q <= POS_MAX;
				omax_x_q <= POS_MIN;
				omin_y_q <= POS_MAX;
				omax_y_q <= POS_MIN;
				nmin_x_q <= POS_MAX;
				nmax_x_q <= POS_MIN;
				nmin_y_q <= POS_MAX;
				nmax_y_q <= POS_MIN;
			end else begin
				omin_x_q <= omin_x;
				omax_x_q <= omax_x;
				omin_y_q <= omin_y;
				omax_y_q <= omax_y;
				nmin_x_q <= nmin_x;
				nmax_x_q <= nmax_x;
				nmin_y_q <= nmin_y;
				nmax_y_q <= nmax_y;
			end
		end
	end

	// Net record, new box in the low bits, query-end flag on top.
	assign push      = vld_s1 & end_s1;
	assign push_data = {qend_s1, w_s1, omax_y, omin_y, omax_x, omin_x,
		nmax_y, nmin_y, nmax_x, nmin_x};

endmodule

// ----- design/hmd_queue.sv -----
// Short register queue of net records between front and back of the core.
// Reports not-empty and room for two more records.
// Depends on hmd_pkg.
module hmd_queue import hmd_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output hmd_qstat_t       qstat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Storage; entries need no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head            = mem_q[rd_ptr_q];
	assign qstat.not_empty = (count_q != '0);
	assign qstat.room2     = (count_q <= CNT_W'(DEPTH - 2));

endmodule

// ----- design/hmd_back.sv -----
// Back part of the move-delta core: spans, HPWL difference, weighting with
// saturation, and the saturating query total in the output register.
// Depends on hmd_pkg.
module hmd_back import hmd_pkg::*; #(
	parameter int WEIGHT_WIDTH = WEIGHT_WIDTH_DEF,
	parameter int POS_W        = pos_width(COORD_WIDTH_DEF),
	parameter int REC_W        = 8 * POS_W + WEIGHT_WIDTH + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [REC_W-1:0]         head,
	input  hmd_qstat_t               qstat,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [NET_W-1:0]  net_delta,
	output logic signed [TOT_W-1:0]  total_delta,
	output logic                     query_done
);

	localparam int MAG_W = POS_W + 1;
	localparam int HALF  = MAG_W / 2;
	localparam int PW    = MAG_W + WEIGHT_WIDTH;
	localparam int CMP_W = (PW > NET_W + 1) ? PW : NET_W + 1;
	localparam logic [CMP_W-1:0] LIM_NEG = CMP_W'(1) << (NET_W - 1);
	localparam logic [CMP_W-1:0] LIM_POS = LIM_NEG - 1'b1;
	localparam logic signed [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W - 1){1'b1}}};
	localparam logic signed [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W - 1){1'b0}}};

	logic                           adv;
	logic [POS_W-1:0]               box [8];

	logic                           vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic                           q_s1, q_s2, q_s3, q_s4, q_s5, q_s6;
	logic [WEIGHT_WIDTH-1:0]        w_s1, w_s2, w_s3;
	logic [POS_W-1:0]               snx_s1, sny_s1, sox_s1, soy_s1;
	logic [MAG_W-1:0]               sn_s2, so_s2;
	logic [MAG_W-1:0]               mag_s3;
	logic                           neg_s3, neg_s4, neg_s5;
	logic [HALF+WEIGHT_WIDTH-1:0]   pp_lo_s4;
	logic [PW-HALF-1:0]             pp_hi_s4;
	logic [PW-1:0]                  prod_s5;
	logic [CMP_W-1:0]               prod_c, prod_sat, lim;
	logic signed [NET_W-1:0]        net_s6;
	logic signed [TOT_W:0]          sum;
	logic signed [TOT_W-1:0]        tot;

	logic                           out_vld_q;
	logic signed [TOT_W-1:0]        run_q;

	// The whole back pipeline moves whenever the output register can load.
	assign adv = !out_vld_q || out_ready;
	assign pop = adv && qstat.not_empty;

	// Record fields: new box in slots 0..3, old box in slots 4..7.
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			box[k] = head[k * POS_W +: POS_W];
		end
	end

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pop;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	// Stage 1: box spans. Spans are never negative, so POS_W unsigned bits hold them.
	always_ff @(posedge clk) begin
		if (adv) begin
			snx_s1 <= box[1] - box[0];
			sny_s1 <= box[3] - box[2];
			sox_s1 <= box[5] - box[4];
			soy_s1 <= box[7] - box[6];
			w_s1   <= head[8 * POS_W +: WEIGHT_WIDTH];
			q_s1   <= head[8 * POS_W + WEIGHT_WIDTH];
		end
	end

	// Stage 2: new and old half perimeters.
	always_ff @(posedge clk) begin
		if (adv) begin
			sn_s2 <= MAG_W'(snx_s1) + MAG_W'(sny_s1);
			so_s2 <= MAG_W'(sox_s1) + MAG_W'(soy_s1);
			w_s2  <= w_s1;
			q_s2  <= q_s1;
		end
	end

	// Stage 3: sign and magnitude of the difference.
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3 <= so_s2 > sn_s2;
			mag_s3 <= (so_s2 > sn_s2) ? so_s2 - sn_s2 : sn_s2 - so_s2;
			w_s3   <= w_s2;
			q_s3   <= q_s2;
		end
	end

	// Stage 4: two partial products of magnitude times weight.
	always_ff @(posedge clk) begin
		if (adv) begin
			pp_lo_s4 <= mag_s3[HALF-1:0] * w_s3;
			pp_hi_s4 <= mag_s3[MAG_W-1:HALF] * w_s3;
			neg_s4   <= neg_s3;
			q_s4     <= q_s3;
		end
	end

	// Stage 5: full product.
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s5 <= (PW'(pp_hi_s4) << HALF) + PW'(pp_lo_s4);
			neg_s5  <= neg_s4;
			q_s5    <= q_s4;
		end
	end

	// Stage 6: clamp the product to the net range and apply the sign.
	always_comb begin
		prod_c   = CMP_W'(prod_s5);
		lim      = neg_s5 ? LIM_NEG : LIM_POS;
		prod_sat = (prod_c > lim) ? lim : prod_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			net_s6 <= neg_s5 ? -NET_W'(prod_sat) : NET_W'(prod_sat);
			q_s6   <= q_s5;
		end
	end

	// Saturating running total.
	always_comb begin
		sum = (TOT_W + 1)'(run_q) + (TOT_W + 1)'(net_s6);
		if (sum[TOT_W] != sum[TOT_W-1]) begin
			tot = sum[TOT_W] ? TOT_MIN : TOT_MAX;
		end else begin
			tot = sum[TOT_W-1:0];
		end
	end

	// Output register and query accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			run_q     <= '0;
		end else if (adv) begin
			out_vld_q <= vld_s6;
			if (vld_s6) begin
				run_q <= q_s6 ? '0 : tot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s6) begin
			net_delta   <= net_s6;
			total_delta <= tot;
			query_done  <= q_s6;
		end
	end

	assign out_valid = out_vld_q;

endmodule

// ----- design/hpwl_move_delta_core.sv -----
// Top level of the half-perimeter wirelength move-delta core.
// Instantiates hmd_front, hmd_queue and hmd_back; depends on hmd_pkg.
//
// Usage: the slave stream carries one pin per request; tlast marks the last
// pin of a net, tuser[1] the last pin of the query, tuser[0] a moved node.
// Each net end produces one request on the master stream holding the weighted
// half-perimeter change of that net and the saturating total of the query so
// far; master tlast marks the final total of a query, after which the total
// restarts at zero.
// Throughput is one pin per cycle while s_axis_tready is high. After the edge
// that accepts its last pin, a net result passes through the pin stage, the
// queue entry, six back stages and the output register in that order.
// When the master side stalls, results collect in a four-entry record queue;
// s_axis_tready drops once it holds three records, so a stall reaches the
// input only after a few net ends.
// Reset clears all boxes, the query total, the queue and the valid flags;
// s_axis_tready is high right after reset.
module hpwl_move_delta_core import hmd_pkg::*; #(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int WEIGHT_WIDTH = WEIGHT_WIDTH_DEF,
	localparam int IN_DATA_W   = in_data_width(COORD_WIDTH, WEIGHT_WIDTH),
	localparam int OUT_DATA_W  = ((NET_W + TOT_W + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// node_x, node_y, pin_dx, pin_dy, moved_x, moved_y, net_weight, zero fill
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// is_moved, last_of_query
	input  logic [1:0]            s_axis_tuser,
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// net_delta, total_delta, zero fill
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast
);

	localparam int POS_W     = pos_width(COORD_WIDTH);
	localparam int REC_W     = 8 * POS_W + WEIGHT_WIDTH + 1;
	localparam int OUT_PAD_W = OUT_DATA_W - NET_W - TOT_W;
	localparam int NY_LO     = COORD_WIDTH;
	localparam int OX_LO     = 2 * COORD_WIDTH;
	localparam int OY_LO     = OX_LO + OFFSET_W;
	localparam int MX_LO     = OY_LO + OFFSET_W;
	localparam int MY_LO     = MX_LO + COORD_WIDTH;
	localparam int W_LO      = MY_LO + COORD_WIDTH;

	logic                    push, pop;
	logic [REC_W-1:0]        push_data, head;
	hmd_qstat_t              qstat;
	logic signed [NET_W-1:0] net_delta;
	logic signed [TOT_W-1:0] total_delta;

	// Pin intake and bounding boxes.
	hmd_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.WEIGHT_WIDTH(WEIGHT_WIDTH),
		.POS_W       (POS_W),
		.REC_W       (REC_W)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.node_x         (s_axis_tdata[COORD_WIDTH-1:0]),
		.node_y         (s_axis_tdata[NY_LO +: COORD_WIDTH]),
		.pin_dx         (s_axis_tdata[OX_LO +: OFFSET_W]),
		.pin_dy         (s_axis_tdata[OY_LO +: OFFSET_W]),
		.is_moved       (s_axis_tuser[0]),
		.moved_x        (s_axis_tdata[MX_LO +: COORD_WIDTH]),
		.moved_y        (s_axis_tdata[MY_LO +: COORD_WIDTH]),
		.net_weight     (s_axis_tdata[W_LO +: WEIGHT_WIDTH]),
		.last_pin_of_net(s_axis_tlast),
		.last_of_query  (s_axis_tuser[1]),
		.qstat          (qstat),
		.push           (push),
		.push_data      (push_data)
	);

	// Net records waiting for the back part.
	hmd_queue #(
		.WIDTH(REC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	// Weighting and totals.
	hmd_back #(
		.WEIGHT_WIDTH(WEIGHT_WIDTH),
		.POS_W       (POS_W),
		.REC_W       (REC_W)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstat      (qstat),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.net_delta  (net_delta),
		.total_delta(total_delta),
		.query_done (m_axis_tlast)
	);

	assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, total_delta, net_delta};

endmodule

// ----- design/hmd_checker.sv -----
// Port-level checker for the move-delta core, bound to the top level.
// Tracks open net ends and the query total seen on the master stream.
// Depends on hmd_pkg.
module hmd_checker import hmd_pkg::*; (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	input  logic                                   s_axis_tready,
	input  logic [1:0]                             s_axis_tuser,
	input  logic                                   s_axis_tlast,
	input  logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	input  logic [((NET_W + TOT_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
	input  logic                                   m_axis_tlast
);

	localparam logic signed [TOT_W-1:0] TOT_MAX = {1'b0, {(TOT_W - 1){1'b1}}};
	localparam logic signed [TOT_W-1:0] TOT_MIN = {1'b1, {(TOT_W - 1){1'b0}}};

	logic                    in_end, out_acc;
	logic [7:0]              pend_q;
	logic                    first_q;
	logic signed [TOT_W-1:0] prev_q;
	logic signed [NET_W-1:0] net;
	logic signed [TOT_W-1:0] total, net_ext, exp_tot;
	logic signed [TOT_W:0]   sum;

	assign in_end  = s_axis_tvalid && s_axis_tready && (s_axis_tlast || s_axis_tuser[1]);
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign net     = m_axis_tdata[NET_W-1:0];
	assign total   = m_axis_tdata[NET_W +: TOT_W];
	assign net_ext = TOT_W'(net);

	// Expected total when the query continues.
	always_comb begin
		sum = (TOT_W + 1)'(prev_q) + (TOT_W + 1)'(net);
		if (sum[TOT_W] != sum[TOT_W-1]) begin
			exp_tot = sum[TOT_W] ? TOT_MIN : TOT_MAX;
		end else begin
			exp_tot = sum[TOT_W-1:0];
		end
	end

	// Count of net ends taken in but not yet delivered, and the last total.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			first_q <= 1'b1;
			prev_q  <= '0;
		end else begin
			if (in_end && !out_acc) begin
				pend_q <= pend_q + 1'b1;
			end else if (out_acc && !in_end) begin
				pend_q <= pend_q - 1'b1;
			end
			if (out_acc) begin
				first_q <= m_axis_tlast;
				prev_q  <= total;
			end
		end
	end

	// No result appears without a net end that caused it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pend_q != '0)
		else $error("result delivered with no open net end");

	// The first net of a query starts the total from zero.
	a_first_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && first_q |-> total == net_ext)
		else $error("query total did not restart at the net delta");

	// Later nets add to the previous total with saturation.
	a_run_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !first_q |-> total == exp_tot)
		else $error("query total is not the saturated running sum");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

endmodule

bind hpwl_move_delta_core hmd_checker u_hmd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tuser (s_axis_tuser),
	.s_axis_tlast (s_axis_tlast),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast)
);
